FILE: rtl/core/prm_pkg.sv
// Shared types and codes for the partition replica map.
// Used by the top unit, prm_ctrl and prm_dpath; depends on nothing.
package prm_pkg;

    // Command codes of an input item.
    localparam logic [2:0] CMD_SET_WRITE = 3'd0;
    localparam logic [2:0] CMD_ADD_READ  = 3'd1;
    localparam logic [2:0] CMD_GET_WRITE = 3'd2;
    localparam logic [2:0] CMD_GET_READ  = 3'd3;
    localparam logic [2:0] CMD_REMOVE    = 3'd4;

    // Status codes of a result item.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_TABLE = 3'd1;
    localparam logic [2:0] ST_RANGE    = 3'd2;
    localparam logic [2:0] ST_PRESENT  = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;
    localparam logic [2:0] ST_BAD_NODE = 3'd5;

    // Reset value of the partitions-in-use register.
    localparam logic [12:0] PIU_RESET = 13'd4096;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_we;     // write one zero row of the clearing pass
        logic accept;     // take the input item and read its row
        logic commit;     // finish the item and load the output register
        logic walk_init;  // start the remove walk at table 0, partition 0
        logic walk_rd;    // read the current walk row
        logic walk_wr;    // write back the current walk row
        logic walk_adv;   // move the walk to the next table
    } t_ctrl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;   // the clearing pass is on its last row
        logic remove_go;  // the offered item is a remove with a real node
        logic out_free;   // the output register can take a result
        logic walk_ok;    // the walk row is in a present table and in range
        logic walk_last;  // the walk is on the last table
    } t_ctrl_stat;

endpackage

FILE: rtl/core/partition_replica_map_unit.sv
// Partition replica map: per namespace and partition, write owner and read replicas.
// Set, add and get: the item is accepted with a row memory read, then finished with its write
// and the output register load once that register is free; no new item is taken until then.
// A remove with a real node walks the partitions below the partitions-in-use limit in every
// present table, reading and writing back each row, then moving on to the next table.
// Reset (synchronous, active low) starts a clearing pass over all NAMESPACES*PARTITIONS rows,
// one row a cycle, during which no item is accepted; configuration writes are taken.
module partition_replica_map_unit #(
    parameter int NAMESPACES = 8,
    parameter int PARTITIONS = 4096,
    parameter int REPLICAS   = 4,
    parameter int NODE_BITS  = 6
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_command,
    input  logic [2:0]  i_namespace_id,
    input  logic [11:0] i_partition_id,
    input  logic [5:0]  i_node_id,
    input  logic        i_cfg_we,
    input  logic [12:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [5:0]  o_result_node,
    output logic [2:0]  o_status
);

    prm_pkg::t_ctrl_cmd  cmd;
    prm_pkg::t_ctrl_stat stat;
    logic                idle;

    prm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_idle     (idle)
    );

    prm_dpath #(
        .NAMESPACES (NAMESPACES),
        .PARTITIONS (PARTITIONS),
        .REPLICAS   (REPLICAS),
        .NODE_BITS  (NODE_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_command      (i_command),
        .i_namespace_id (i_namespace_id),
        .i_partition_id (i_partition_id),
        .i_node_id      (i_node_id),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_result_node  (o_result_node),
        .o_status       (o_status)
    );

    // Items are taken only between commands.
    assign o_in_stall = !idle;

    // One item at a time: an accepted item closes the input until it is done.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item accepted while one is in progress");

    // Only defined status codes leave the block.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= prm_pkg::ST_BAD_NODE))
        else $error("undefined status code on output");

    // A failed command never returns a node.
    a_fail_no_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != prm_pkg::ST_OK) |-> (o_result_node == 6'd0))
        else $error("node returned with a failing status");

endmodule

FILE: rtl/core/prm_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Standalone; depends on nothing.
module prm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/prm_ctrl.sv
// Controller state machine of the partition replica map.
// Depends on prm_pkg for the command and status structs.
module prm_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  prm_pkg::t_ctrl_stat i_stat,
    output prm_pkg::t_ctrl_cmd  o_cmd,
    output logic                o_idle
);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_EXEC  = 5'b00100,
        S_RM_RD = 5'b01000,
        S_RM_WR = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.remove_go) begin
                        o_cmd.walk_init = 1'b1;
                        n_state = S_RM_RD;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_RM_RD: begin
                if (i_stat.walk_ok) begin
                    o_cmd.walk_rd = 1'b1;
                    n_state = S_RM_WR;
                end else if (i_stat.walk_last) begin
                    n_state = S_EXEC;
                end else begin
                    o_cmd.walk_adv = 1'b1;
                end
            end
            S_RM_WR: begin
                o_cmd.walk_wr = 1'b1;
                n_state = S_RM_RD;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // State register; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_idle = (r_state == S_IDLE);

endmodule

FILE: rtl/core/prm_dpath.sv
// Datapath of the partition replica map: row memory, table flags,
// round-robin counter, remove walk and output register.
// Depends on prm_pkg and prm_ram.
module prm_dpath #(
    parameter int NAMESPACES = 8,
    parameter int PARTITIONS = 4096,
    parameter int REPLICAS   = 4,
    parameter int NODE_BITS  = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  prm_pkg::t_ctrl_cmd  i_cmd,
    output prm_pkg::t_ctrl_stat o_stat,
    input  logic [2:0]          i_command,
    input  logic [2:0]          i_namespace_id,
    input  logic [11:0]         i_partition_id,
    input  logic [5:0]          i_node_id,
    input  logic                i_cfg_we,
    input  logic [12:0]         i_cfg_data,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [5:0]          o_result_node,
    output logic [2:0]          o_status
);

    localparam int ROWS   = NAMESPACES * PARTITIONS;
    localparam int ROW_W  = ROWS > 1 ? $clog2(ROWS) : 1;
    localparam int NS_W   = NAMESPACES > 1 ? $clog2(NAMESPACES) : 1;
    localparam int PID_W  = PARTITIONS > 1 ? $clog2(PARTITIONS) : 1;
    localparam int CNT_W  = $clog2(REPLICAS + 1);
    localparam int CNT_LO = NODE_BITS * (REPLICAS + 1);
    localparam int WORD_W = CNT_LO + CNT_W;

    // Configuration and captured item.
    logic [12:0]          r_piu;
    logic [2:0]           r_cmd;
    logic [2:0]           r_ns;
    logic [11:0]          r_pid;
    logic [NODE_BITS-1:0] r_node;
    logic [ROW_W-1:0]     r_row;
    logic [ROW_W-1:0]     r_clr;
    logic [NAMESPACES-1:0] r_tp;
    logic [31:0]          r_rr;
    logic [CNT_W-1:0]     r_res [REPLICAS];
    logic [CNT_W-1:0]     n_res [REPLICAS];
    logic [NS_W-1:0]      r_wt;
    logic [12:0]          r_wp;
    logic                 r_out_valid;
    logic [5:0]           r_out_node;
    logic [2:0]           r_out_status;

    logic [12:0]          lim;
    logic [NS_W-1:0]      ns_idx;
    logic [ROW_W-1:0]     in_row;
    logic [ROW_W-1:0]     walk_row;
    logic [WORD_W-1:0]    rd_word;
    logic [WORD_W-1:0]    ex_word;
    logic [WORD_W-1:0]    dr_word;
    logic [WORD_W-1:0]    wdata;
    logic                 ex_we;
    logic                 tp_set;
    logic                 rr_step;
    logic [NODE_BITS-1:0] ex_res;
    logic [2:0]           ex_status;

    logic [NODE_BITS-1:0] rep [REPLICAS];
    logic [NODE_BITS-1:0] owner;
    logic [CNT_W-1:0]     cnt;

    assign lim = (r_piu > 13'(PARTITIONS)) ? 13'(PARTITIONS) : r_piu;
    assign ns_idx = NS_W'(r_ns);
    assign in_row = ROW_W'(NS_W'(i_namespace_id)) * ROW_W'(PARTITIONS)
                  + ROW_W'(PID_W'(i_partition_id));
    assign walk_row = ROW_W'(r_wt) * ROW_W'(PARTITIONS) + ROW_W'(r_wp[PID_W-1:0]);

    // Unpack the row that was read.
    always_comb begin
        owner = rd_word[NODE_BITS-1:0];
        cnt   = rd_word[CNT_LO +: CNT_W];
        for (int j = 0; j < REPLICAS; j++) begin
            rep[j] = rd_word[NODE_BITS*(j+1) +: NODE_BITS];
        end
    end

    // Residues of the incremented round-robin counter for each list length.
    always_comb begin
        for (int j = 0; j < REPLICAS; j++) begin
            if (r_rr == '1 || r_res[j] == CNT_W'(j)) begin
                n_res[j] = '0;
            end else begin
                n_res[j] = r_res[j] + CNT_W'(1);
            end
        end
    end

    // Execution of one item on its row.
    always_comb begin
        logic dup;
        ex_word   = rd_word;
        ex_we     = 1'b0;
        tp_set    = 1'b0;
        rr_step   = 1'b0;
        ex_res    = '0;
        ex_status = prm_pkg::ST_OK;
        dup       = 1'b0;
        case (r_cmd)
            prm_pkg::CMD_SET_WRITE, prm_pkg::CMD_ADD_READ: begin
                if (r_node == '0) begin
                    ex_status = prm_pkg::ST_BAD_NODE;
                end else if (32'(r_ns) >= 32'(NAMESPACES)) begin
                    ex_status = prm_pkg::ST_NO_TABLE;
                end else begin
                    tp_set = 1'b1;
                    if ({1'b0, r_pid} >= lim) begin
                        ex_status = prm_pkg::ST_RANGE;
                    end else if (r_cmd == prm_pkg::CMD_SET_WRITE) begin
                        ex_word[NODE_BITS-1:0] = r_node;
                        ex_we = 1'b1;
                    end else begin
                        for (int j = 0; j < REPLICAS; j++) begin
                            if (CNT_W'(j) < cnt && rep[j] == r_node) begin
                                dup = 1'b1;
                            end
                        end
                        if (dup) begin
                            ex_status = prm_pkg::ST_PRESENT;
                        end else if (cnt == CNT_W'(REPLICAS)) begin
                            ex_word[NODE_BITS +: NODE_BITS] = r_node;
                            ex_we = 1'b1;
                            ex_status = prm_pkg::ST_FULL;
                        end else begin
                            for (int j = 0; j < REPLICAS; j++) begin
                                if (cnt == CNT_W'(j)) begin
                                    ex_word[NODE_BITS*(j+1) +: NODE_BITS] = r_node;
                                end
                            end
                            ex_word[CNT_LO +: CNT_W] = cnt + CNT_W'(1);
                            ex_we = 1'b1;
                        end
                    end
                end
            end
            prm_pkg::CMD_GET_WRITE, prm_pkg::CMD_GET_READ: begin
                if (32'(r_ns) >= 32'(NAMESPACES) || !r_tp[ns_idx]) begin
                    ex_status = prm_pkg::ST_NO_TABLE;
                end else if ({1'b0, r_pid} >= lim) begin
                    ex_status = prm_pkg::ST_RANGE;
                end else if (r_cmd == prm_pkg::CMD_GET_WRITE) begin
                    ex_res = owner;
                end else if (cnt != '0) begin
                    rr_step = 1'b1;
                    for (int j = 0; j < REPLICAS; j++) begin
                        if (cnt == CNT_W'(j + 1)) begin
                            for (int k = 0; k < REPLICAS; k++) begin
                                if (n_res[j] == CNT_W'(k)) begin
                                    ex_res = rep[k];
                                end
                            end
                        end
                    end
                end
            end
            prm_pkg::CMD_REMOVE: begin
                if (r_node == '0) begin
                    ex_status = prm_pkg::ST_BAD_NODE;
                end
            end
            default: ex_status = prm_pkg::ST_OK;
        endcase
    end

    // Removal of the node from one walk row, compacting the read list.
    always_comb begin
        logic passed;
        dr_word = rd_word;
        passed  = 1'b0;
        if (owner == r_node) begin
            dr_word[NODE_BITS-1:0] = '0;
        end
        for (int k = 0; k < REPLICAS; k++) begin
            if (CNT_W'(k) < cnt && rep[k] == r_node) begin
                passed = 1'b1;
            end
            if (passed) begin
                dr_word[NODE_BITS*(k+1) +: NODE_BITS] =
                    (k + 1 < REPLICAS) ? rep[(k + 1) % REPLICAS] : '0;
            end
        end
        if (passed) begin
            dr_word[CNT_LO +: CNT_W] = cnt - CNT_W'(1);
        end
    end

    assign wdata = i_cmd.clr_we ? '0 : (i_cmd.commit ? ex_word : dr_word);

    prm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ROWS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (i_cmd.clr_we | (i_cmd.commit & ex_we) | i_cmd.walk_wr),
        .i_waddr (i_cmd.clr_we ? r_clr : r_row),
        .i_wdata (wdata),
        .i_re    (i_cmd.accept | i_cmd.walk_rd),
        .i_raddr (i_cmd.accept ? in_row : walk_row),
        .o_rdata (rd_word)
    );

    // Control registers: configuration, clearing counter, table flags, round-robin counter, output valid, walk.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piu       <= prm_pkg::PIU_RESET;
            r_clr       <= '0;
            r_tp        <= '0;
            r_rr        <= '0;
            r_out_valid <= 1'b0;
            r_wt        <= '0;
            r_wp        <= '0;
            for (int j = 0; j < REPLICAS; j++) begin
                r_res[j] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_piu <= i_cfg_data;
            end
            if (i_cmd.clr_we) begin
                r_clr <= r_clr + ROW_W'(1);
            end
            if (i_cmd.commit && tp_set) begin
                r_tp[ns_idx] <= 1'b1;
            end
            if (i_cmd.commit && rr_step) begin
                r_rr <= r_rr + 32'd1;
                for (int j = 0; j < REPLICAS; j++) begin
                    r_res[j] <= n_res[j];
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.walk_init) begin
                r_wt <= '0;
                r_wp <= '0;
            end else if (i_cmd.walk_adv) begin
                r_wt <= r_wt + NS_W'(1);
                r_wp <= '0;
            end else if (i_cmd.walk_wr) begin
                r_wp <= r_wp + 13'd1;
            end
        end
    end

    // Payload registers: captured item, row address, result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd  <= i_command;
            r_ns   <= i_namespace_id;
            r_pid  <= i_partition_id;
            r_node <= NODE_BITS'(i_node_id);
            r_row  <= in_row;
        end else if (i_cmd.walk_rd) begin
            r_row  <= walk_row;
        end
        if (i_cmd.commit) begin
            r_out_node   <= 6'(ex_res);
            r_out_status <= ex_status;
        end
    end

    assign o_stat.clr_last  = (r_clr == ROW_W'(ROWS - 1));
    assign o_stat.remove_go = (i_command == prm_pkg::CMD_REMOVE)
                            && (NODE_BITS'(i_node_id) != '0);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;
    assign o_stat.walk_ok   = r_tp[r_wt] && (r_wp < lim);
    assign o_stat.walk_last = (r_wt == NS_W'(NAMESPACES - 1));

    assign o_out_valid   = r_out_valid;
    assign o_result_node = r_out_node;
    assign o_status      = r_out_status;

endmodule
